// File: rtl/bpl_pkg.sv
package bpl_pkg;

  // Duty scale that the setpoint is normalized against
  localparam int unsigned PWM_FULL_SCALE = 1023;

  // Filter shifts
  localparam int unsigned CUR_SHIFT  = 6;
  localparam int unsigned RAMP_SHIFT = 7;

  // Reset values of the configuration registers
  localparam logic [9:0]  LOW_VOLT_RST = 10'd310;
  localparam logic [15:0] MAX_CUR_RST  = 16'd25000;

  // Configuration register indexes
  localparam logic REG_LOW_VOLT = 1'b0;
  localparam logic REG_MAX_CUR  = 1'b1;

  // Opcodes of an input beat
  localparam logic [1:0] OPC_TICK = 2'd0;
  localparam logic [1:0] OPC_SET  = 2'd1;
  localparam logic [1:0] OPC_LOAD = 2'd2;
  localparam logic [1:0] OPC_NONE = 2'd3;

  // Reciprocal multipliers: floor(n/5) = (n*M5)>>SH5 for n < 2^13,
  // floor(n/100) = (n*M100)>>SH100 for n < 2^18
  localparam logic [18:0] M5    = 19'd6554;
  localparam int unsigned SH5   = 15;
  localparam logic [18:0] M100  = 19'd335545;
  localparam int unsigned SH100 = 25;

  // Setpoint divider: target*full_current over (mode+1)*PWM_FULL_SCALE
  localparam int unsigned NUM_W  = 26;
  localparam int unsigned DEN_W  = 18;
  localparam int unsigned QBITS  = NUM_W - ($clog2(PWM_FULL_SCALE + 1) - 1);
  localparam int unsigned CNT_W  = $clog2(QBITS);
  localparam int unsigned SP_MAX = 65535;

  // Largest value the ramp accumulator can reach
  localparam logic [17:0] RAMP_MAX = 18'd130944;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_FILT,
    DP_FULL,
    DP_VMUL,
    DP_VREG,
    DP_DIV,
    DP_SP,
    DP_CERR,
    DP_CINT,
    DP_CMUL_E,
    DP_CMUL_I,
    DP_CREG,
    DP_DRIVE,
    DP_SET,
    DP_LOAD
  } dp_op_t;

  // Sequencer branch kinds
  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_DISPATCH,
    BR_LOOP,
    BR_EMIT
  } br_t;

  localparam int unsigned UA_W = 4;

  typedef struct packed {
    dp_op_t          op;
    br_t             br;
    logic            cnt_load;
    logic [UA_W-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_load;
  } dp_ctl_t;

  // Program addresses
  localparam logic [UA_W-1:0] UA_WAIT   = 4'd0;
  localparam logic [UA_W-1:0] UA_TICK   = 4'd1;
  localparam logic [UA_W-1:0] UA_FULL   = 4'd2;
  localparam logic [UA_W-1:0] UA_VMUL   = 4'd3;
  localparam logic [UA_W-1:0] UA_VREG   = 4'd4;
  localparam logic [UA_W-1:0] UA_DIV    = 4'd5;
  localparam logic [UA_W-1:0] UA_SP     = 4'd6;
  localparam logic [UA_W-1:0] UA_CERR   = 4'd7;
  localparam logic [UA_W-1:0] UA_CINT   = 4'd8;
  localparam logic [UA_W-1:0] UA_CMUL_E = 4'd9;
  localparam logic [UA_W-1:0] UA_CMUL_I = 4'd10;
  localparam logic [UA_W-1:0] UA_CREG   = 4'd11;
  localparam logic [UA_W-1:0] UA_DRIVE  = 4'd12;
  localparam logic [UA_W-1:0] UA_SET    = 4'd13;
  localparam logic [UA_W-1:0] UA_LOAD   = 4'd14;
  localparam logic [UA_W-1:0] UA_EMIT   = 4'd15;

  // Control store
  function automatic ucode_t ucode_rom(input logic [UA_W-1:0] addr);
    ucode_t w;
    w = '{op: DP_NOP, br: BR_JUMP, cnt_load: 1'b0, tgt: UA_WAIT};
    unique case (addr)
      UA_WAIT:   w = '{op: DP_NOP,    br: BR_DISPATCH, cnt_load: 1'b0, tgt: UA_WAIT};
      UA_TICK:   w = '{op: DP_FILT,   br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_FULL:   w = '{op: DP_FULL,   br: BR_NEXT,     cnt_load: 1'b1, tgt: UA_WAIT};
      UA_VMUL:   w = '{op: DP_VMUL,   br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_VREG:   w = '{op: DP_VREG,   br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_DIV:    w = '{op: DP_DIV,    br: BR_LOOP,     cnt_load: 1'b0, tgt: UA_DIV};
      UA_SP:     w = '{op: DP_SP,     br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_CERR:   w = '{op: DP_CERR,   br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_CINT:   w = '{op: DP_CINT,   br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_CMUL_E: w = '{op: DP_CMUL_E, br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_CMUL_I: w = '{op: DP_CMUL_I, br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_CREG:   w = '{op: DP_CREG,   br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_DRIVE:  w = '{op: DP_DRIVE,  br: BR_JUMP,     cnt_load: 1'b0, tgt: UA_EMIT};
      UA_SET:    w = '{op: DP_SET,    br: BR_JUMP,     cnt_load: 1'b0, tgt: UA_EMIT};
      UA_LOAD:   w = '{op: DP_LOAD,   br: BR_NEXT,     cnt_load: 1'b0, tgt: UA_WAIT};
      UA_EMIT:   w = '{op: DP_NOP,    br: BR_EMIT,     cnt_load: 1'b0, tgt: UA_WAIT};
      default:   w = '{op: DP_NOP,    br: BR_JUMP,     cnt_load: 1'b0, tgt: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/bpl_datapath.sv
module bpl_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpl_pkg::dp_ctl_t     ctl,
  input  logic [9:0]           power_value,
  input  logic signed [16:0]   current_sample,
  input  logic [9:0]           bus_voltage,
  input  logic [1:0]           drive_mode,
  input  logic [9:0]           low_voltage_limit,
  input  logic [15:0]          full_current,
  output logic [9:0]           drive_power,
  output logic signed [16:0]   filtered_current,
  output logic [15:0]          current_setpoint
);
  import bpl_pkg::*;

  // Persistent state
  logic [9:0]         tgt_r, tgt_nxt;
  logic [17:0]        ramp_r, ramp_nxt;
  logic signed [23:0] filt_r, filt_nxt;
  logic signed [15:0] vint_r, vint_nxt;
  logic signed [19:0] cint_r, cint_nxt;
  logic [9:0]         drive_r, drive_nxt;
  logic [15:0]        sp_r, sp_nxt;

  // Latched beat fields
  logic [9:0]         pv_r;
  logic signed [16:0] raw_r;
  logic [9:0]         volt_r;
  logic [1:0]         mode_r;

  // Working registers
  logic signed [10:0] verr_r, verr_nxt;
  logic signed [12:0] full_r, full_nxt;
  logic signed [17:0] cerr_r, cerr_nxt;
  logic signed [11:0] qe_r, qe_nxt;
  logic signed [12:0] creg_r, creg_nxt;
  logic [36:0]        mul_r, mul_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [QBITS-1:0]   nq_r, nq_nxt;

  // Current filter and power ramp steps
  logic signed [24:0] fdiff, fstep;
  logic signed [18:0] rdiff, rstep;
  assign fdiff = $signed({{2{raw_r[16]}}, raw_r, 6'b0}) - $signed({filt_r[23], filt_r});
  assign fstep = fdiff >>> CUR_SHIFT;
  assign rdiff = $signed({2'b0, tgt_r, 7'b0}) - $signed({1'b0, ramp_r});
  assign rstep = rdiff >>> RAMP_SHIFT;

  // Undervoltage integral with clamp to [-5*full, 0]
  logic [10:0]        full_w;
  logic [12:0]        full5;
  logic signed [16:0] vsum, vlim, vclamp, vnew;
  assign full_w = ramp_r[17:7];
  assign full5  = 13'(full_w) * 13'd5;
  assign vsum   = $signed({vint_r[15], vint_r}) + $signed({{6{verr_r[10]}}, verr_r}) + 17'sd1;
  assign vlim   = -$signed({4'b0, full5});
  assign vclamp = (vsum > 17'sd0) ? 17'sd0 : vsum;
  assign vnew   = (vclamp < vlim) ? vlim : vclamp;

  // Shared multiplier operands
  logic [15:0] vneg;
  logic [17:0] cerr_abs, cint_abs, mul_a;
  logic [18:0] mul_b;
  assign vneg     = 16'(-vint_r);
  assign cerr_abs = cerr_r[17] ? 18'(-cerr_r) : 18'(cerr_r);
  assign cint_abs = cint_r[19] ? 18'(-cint_r) : 18'(cint_r);

  always_comb begin
    case (ctl.op)
      DP_FILT: begin
        mul_a = 18'(tgt_r);
        mul_b = 19'(full_current);
      end
      DP_VMUL: begin
        mul_a = 18'(vneg);
        mul_b = M5;
      end
      DP_CMUL_E: begin
        mul_a = cerr_abs;
        mul_b = M100;
      end
      DP_CMUL_I: begin
        mul_a = cint_abs;
        mul_b = M100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Quotients by the constant divisors
  logic [10:0]        q5;
  logic [11:0]        q100;
  logic signed [12:0] q100_s, qi;
  logic signed [11:0] vreg;
  assign q5     = mul_r[SH5+10:SH5];
  assign q100   = mul_r[SH100+11:SH100];
  assign q100_s = $signed({1'b0, q100});
  assign qi     = cint_r[19] ? -q100_s : q100_s;
  assign vreg   = $signed({verr_r[10], verr_r}) - $signed({1'b0, q5});

  // Overcurrent integral with clamp to 0 then to -100*full
  logic signed [20:0] csum, fx, clim, cclamp, cnew;
  assign csum   = $signed({cint_r[19], cint_r}) + $signed({{3{cerr_r[17]}}, cerr_r}) + 21'sd1;
  assign fx     = $signed({{8{full_r[12]}}, full_r});
  assign clim   = -(fx * 21'sd100);
  assign cclamp = (csum > 21'sd0) ? 21'sd0 : csum;
  assign cnew   = (cclamp < clim) ? clim : cclamp;

  // Final drive sum
  logic signed [13:0] dsum;
  assign dsum = $signed({full_r[12], full_r}) +
                (creg_r[12] ? $signed({creg_r[12], creg_r}) : 14'sd0);

  // One restoring divider step
  logic [DEN_W:0]   dsh;
  logic [DEN_W+1:0] ddiff;
  logic             dge;
  assign dsh   = {rem_r, nq_r[QBITS-1]};
  assign ddiff = {1'b0, dsh} - {2'b0, den_r};
  assign dge   = ~ddiff[DEN_W+1];

  // Setpoint saturation
  logic [QBITS+15:0] nq_ext;
  assign nq_ext = {16'b0, nq_r};

  // Next-state decode of the control word
  always_comb begin
    tgt_nxt  = tgt_r;
    ramp_nxt = ramp_r;
    filt_nxt = filt_r;
    vint_nxt = vint_r;
    cint_nxt = cint_r;
    drive_nxt = drive_r;
    sp_nxt   = sp_r;
    verr_nxt = verr_r;
    full_nxt = full_r;
    cerr_nxt = cerr_r;
    qe_nxt   = qe_r;
    creg_nxt = creg_r;
    mul_nxt  = mul_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    nq_nxt   = nq_r;
    unique case (ctl.op)
      DP_NOP: begin
      end
      DP_FILT: begin
        filt_nxt = filt_r + fstep[23:0];
        ramp_nxt = ramp_r + rstep[17:0];
        mul_nxt  = 37'(mul_a * mul_b);
        verr_nxt = $signed({1'b0, volt_r}) - $signed({1'b0, low_voltage_limit});
      end
      DP_FULL: begin
        full_nxt = $signed({2'b0, full_w});
        vint_nxt = vnew[15:0];
        rem_nxt  = DEN_W'(mul_r[NUM_W-1:QBITS]);
        nq_nxt   = mul_r[QBITS-1:0];
        den_nxt  = DEN_W'({1'b0, mode_r} + 3'd1) * DEN_W'(PWM_FULL_SCALE);
      end
      DP_VMUL: begin
        mul_nxt = 37'(mul_a * mul_b);
      end
      DP_VREG: begin
        if (vreg < 12'sd0) begin
          full_nxt = full_r + $signed({vreg[11], vreg});
        end
      end
      DP_DIV: begin
        rem_nxt = dge ? ddiff[DEN_W-1:0] : dsh[DEN_W-1:0];
        nq_nxt  = {nq_r[QBITS-2:0], dge};
      end
      DP_SP: begin
        sp_nxt = (nq_ext > (QBITS+16)'(SP_MAX)) ? 16'hFFFF : nq_ext[15:0];
      end
      DP_CERR: begin
        cerr_nxt = $signed({2'b0, sp_r}) - $signed({raw_r[16], raw_r});
      end
      DP_CINT: begin
        cint_nxt = cnew[19:0];
      end
      DP_CMUL_E: begin
        mul_nxt = 37'(mul_a * mul_b);
      end
      DP_CMUL_I: begin
        qe_nxt  = cerr_r[17] ? 12'(-q100_s) : 12'(q100_s);
        mul_nxt = 37'(mul_a * mul_b);
      end
      DP_CREG: begin
        creg_nxt = $signed({qe_r[11], qe_r}) + qi;
      end
      DP_DRIVE: begin
        if (dsum < 14'sd0) begin
          drive_nxt = '0;
        end else if (dsum > 14'sd1023) begin
          drive_nxt = 10'd1023;
        end else begin
          drive_nxt = dsum[9:0];
        end
      end
      DP_SET: begin
        tgt_nxt = pv_r;
      end
      DP_LOAD: begin
        tgt_nxt   = pv_r;
        ramp_nxt  = {1'b0, pv_r, 7'b0};
        drive_nxt = pv_r;
      end
      default: begin
      end
    endcase
  end

  // Limiter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r   <= '0;
      ramp_r  <= '0;
      filt_r  <= '0;
      vint_r  <= '0;
      cint_r  <= '0;
      drive_r <= '0;
      sp_r    <= '0;
    end else begin
      tgt_r   <= tgt_nxt;
      ramp_r  <= ramp_nxt;
      filt_r  <= filt_nxt;
      vint_r  <= vint_nxt;
      cint_r  <= cint_nxt;
      drive_r <= drive_nxt;
      sp_r    <= sp_nxt;
    end
  end

  // Beat capture and scratch registers
  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      pv_r   <= power_value;
      raw_r  <= current_sample;
      volt_r <= bus_voltage;
      mode_r <= drive_mode;
    end
    verr_r <= verr_nxt;
    full_r <= full_nxt;
    cerr_r <= cerr_nxt;
    qe_r   <= qe_nxt;
    creg_r <= creg_nxt;
    mul_r  <= mul_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    nq_r   <= nq_nxt;
  end

  assign drive_power      = drive_r;
  assign filtered_current = filt_r[22:6];
  assign current_setpoint = sp_r;

`ifndef SYNTH
  // Partial remainder never reaches the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == DP_DIV) |-> (rem_r < den_r))
    else $error("divider remainder out of range");

  // Undervoltage integral only ever pulls down
  a_vint_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    vint_r <= 16'sd0)
    else $error("voltage integral positive");

  // Ramp stays within the target scale
  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_r <= RAMP_MAX)
    else $error("ramp accumulator above full scale");
`endif

endmodule

// File: rtl/bldc_power_limiter.sv
// Tick beat: filters, undervoltage trim, setpoint divider loop (one quotient bit per
// cycle, 17 steps), overcurrent trim and drive step, then the result is emitted.
// Set-target and load beats update the target and emit; the unused opcode emits at
// once. One beat is in flight at a time; a new beat is taken the cycle after the result
// enters the output register. Reset (rst_n low, synchronous) clears all limiter state
// and loads the configuration registers with 310 and 25000.
module bldc_power_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // power_value, current_sample, bus_voltage, drive_mode
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // drive_power, filtered_current, current_setpoint
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import bpl_pkg::*;

  logic [UA_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_tvalid_r;
  logic [47:0]      out_tdata_r;
  logic [9:0]       low_volt_r;
  logic [15:0]      max_cur_r;

  ucode_t  uw;
  dp_ctl_t ctl;
  logic    in_beat, emit_go;

  logic [9:0]         dp_drive;
  logic signed [16:0] dp_filt;
  logic [15:0]        dp_sp;

  assign uw        = ucode_rom(pc_r);
  assign in_tready = (uw.br == BR_DISPATCH);
  assign in_beat   = in_tvalid && in_tready;
  assign emit_go   = (uw.br == BR_EMIT) && (!out_tvalid_r || out_tready);

  assign ctl.op      = uw.op;
  assign ctl.in_load = in_beat;

  // Sequencer: next address and loop counter
  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    unique case (uw.br)
      BR_NEXT: pc_nxt = pc_r + 4'd1;
      BR_JUMP: pc_nxt = uw.tgt;
      BR_DISPATCH: begin
        if (in_beat) begin
          unique case (in_tuser)
            OPC_TICK: pc_nxt = UA_TICK;
            OPC_SET:  pc_nxt = UA_SET;
            OPC_LOAD: pc_nxt = UA_LOAD;
            OPC_NONE: pc_nxt = UA_EMIT;
            default:  pc_nxt = UA_EMIT;
          endcase
        end
      end
      BR_LOOP: begin
        if (cnt_r != '0) begin
          pc_nxt  = uw.tgt;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          pc_nxt = pc_r + 4'd1;
        end
      end
      BR_EMIT: begin
        if (emit_go) begin
          pc_nxt = uw.tgt;
        end
      end
      default: pc_nxt = UA_WAIT;
    endcase
    if (uw.cnt_load) begin
      cnt_nxt = CNT_W'(QBITS - 1);
    end
  end

  // Sequencer, output register and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= UA_WAIT;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      low_volt_r   <= LOW_VOLT_RST;
      max_cur_r    <= MAX_CUR_RST;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
      if (emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOW_VOLT: low_volt_r <= cfg_wdata[9:0];
          REG_MAX_CUR:  max_cur_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_tdata_r <= {5'b0, dp_sp, dp_filt, dp_drive};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  bpl_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .power_value       (in_tdata[9:0]),
    .current_sample    ($signed(in_tdata[26:10])),
    .bus_voltage       (in_tdata[36:27]),
    .drive_mode        (in_tdata[38:37]),
    .low_voltage_limit (low_volt_r),
    .full_current      (max_cur_r),
    .drive_power       (dp_drive),
    .filtered_current  (dp_filt),
    .current_setpoint  (dp_sp)
  );

`ifndef SYNTH
  // A result only appears out of the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(pc_r) == UA_EMIT))
    else $error("result raised outside emit step");

  // An accepted beat always starts a program
  a_accept_leaves_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (pc_r != UA_WAIT))
    else $error("accepted beat not dispatched");

  // Divider loop runs until its count is spent
  a_div_loop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == UA_DIV && cnt_r != '0) |=> (pc_r == UA_DIV))
    else $error("divider loop left early");
`endif

endmodule

// File: verif/bpl_result_checker.sv
module bpl_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [39:0]        in_tdata,   // power_value, current_sample, bus_voltage, drive_mode
  input  logic [1:0]         in_tuser,   // opcode
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [47:0]        out_tdata,  // drive_power, filtered_current, current_setpoint
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output int unsigned        mismatch_count,
  output int unsigned        results_outstanding
);
  import bpl_pkg::*;

  // PI gains, all scaled by GAIN_DIV
  localparam longint FULL_SCALE = longint'(PWM_FULL_SCALE);
  localparam longint V_KP       = 1000;
  localparam longint V_KI       = 200;
  localparam longint I_KP       = 10;
  localparam longint I_KI       = 10;
  localparam longint GAIN_DIV   = 1000;
  localparam longint DRIVE_MAX  = 1023;
  localparam longint SP_LIMIT   = 65535;

  typedef struct {
    logic [9:0]         drive;
    logic signed [16:0] current;
    logic [15:0]        setpoint;
  } limiter_result_t;

  // Configuration copy
  logic [9:0]  low_volt_lim;
  logic [15:0] max_cur;

  // Limiter state
  logic [9:0]         power_target;
  logic [17:0]        ramp_acc;
  logic signed [23:0] cur_filter_acc;
  logic signed [15:0] volt_integ;
  logic signed [19:0] cur_integ;
  logic [9:0]         drive_lvl;
  logic [15:0]        setpoint;

  limiter_result_t expected_results[$];

  initial begin
    mismatch_count      = 0;
    results_outstanding = 0;
  end

  // Tick: filters, setpoint, undervoltage and overcurrent trims
  function automatic void run_tick(input logic signed [16:0] sample, input logic [9:0] volt,
                                   input logic [1:0] mode);
    longint raw, delta, full, sp, verr, vreg, cerr, creg, integ, lim;
    raw   = longint'(sample);
    delta = raw * 64 - longint'(cur_filter_acc);
    cur_filter_acc = 24'(longint'(cur_filter_acc) + (delta >>> CUR_SHIFT));
    delta = longint'(power_target) * 128 - longint'(ramp_acc);
    ramp_acc = 18'(longint'(ramp_acc) + (delta >>> RAMP_SHIFT));
    full  = longint'(ramp_acc) >>> RAMP_SHIFT;

    sp = longint'(power_target) * longint'(max_cur) / (longint'(mode) + 1) / FULL_SCALE;
    if (sp > SP_LIMIT) sp = SP_LIMIT;
    setpoint = 16'(sp);

    // undervoltage trim, integral kept in [-full*5, 0]
    verr  = longint'(volt) - longint'(low_volt_lim);
    integ = longint'(volt_integ) + verr + 1;
    if (integ > 0) integ = 0;
    lim = -full * GAIN_DIV / V_KI;
    if (integ < lim) integ = lim;
    volt_integ = 16'(integ);
    vreg = verr * V_KP / GAIN_DIV + integ * V_KI / GAIN_DIV;
    if (vreg < 0) full += vreg;

    // overcurrent trim against the raw sample; bound may turn positive
    cerr  = sp - raw;
    integ = longint'(cur_integ) + cerr + 1;
    if (integ > 0) integ = 0;
    lim = -full * GAIN_DIV / I_KI;
    if (integ < lim) integ = lim;
    cur_integ = 20'(integ);
    creg = cerr * I_KP / GAIN_DIV + integ * I_KI / GAIN_DIV;
    if (creg < 0) full += creg;

    if (full < 0) full = 0;
    if (full > DRIVE_MAX) full = DRIVE_MAX;
    drive_lvl = 10'(full);
  endfunction

  function automatic limiter_result_t apply_beat(input logic [1:0] op, input logic [39:0] data);
    limiter_result_t r;
    case (op)
      OPC_TICK: run_tick(data[26:10], data[36:27], data[38:37]);
      OPC_SET:  power_target = data[9:0];
      OPC_LOAD: begin
        power_target = data[9:0];
        ramp_acc     = {1'b0, data[9:0], 7'd0};
        drive_lvl    = data[9:0];
      end
      default: ;  // unused opcode leaves the state alone
    endcase
    r.drive    = drive_lvl;
    r.current  = 17'(cur_filter_acc >>> CUR_SHIFT);
    r.setpoint = setpoint;
    return r;
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    limiter_result_t want, got;
    if (!rst_n) begin
      low_volt_lim   = LOW_VOLT_RST;
      max_cur        = MAX_CUR_RST;
      power_target   = '0;
      ramp_acc       = '0;
      cur_filter_acc = '0;
      volt_integ     = '0;
      cur_integ      = '0;
      drive_lvl      = '0;
      setpoint       = '0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOW_VOLT: low_volt_lim = cfg_wdata[9:0];
          REG_MAX_CUR:  max_cur      = cfg_wdata;
          default: ;
        endcase
      end

      // input beat -> expected result
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_beat(in_tuser, in_tdata));

      // result beat -> compare with oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_tdata);
          mismatch_count++;
        end else begin
          want         = expected_results.pop_front();
          got.drive    = out_tdata[9:0];
          got.current  = out_tdata[26:10];
          got.setpoint = out_tdata[42:27];
          if (got.drive !== want.drive)
            report_field("drive_power", longint'(want.drive), longint'(got.drive));
          if (got.current !== want.current)
            report_field("filtered_current", longint'(want.current), longint'(got.current));
          if (got.setpoint !== want.setpoint)
            report_field("current_setpoint", longint'(want.setpoint), longint'(got.setpoint));
        end
      end
    end
    results_outstanding = expected_results.size();
  end

endmodule

// File: verif/bldc_power_limiter_tb.sv
module bldc_power_limiter_tb;
  import bpl_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PRESSURE_HOLD   = 300;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned ITEMS_PER_PHASE = 170;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = OPC_TICK;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = REG_LOW_VOLT;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;

  int unsigned mismatch_count;
  int unsigned results_outstanding;
  int unsigned idle_cycles = 0;

  // stimulus knobs shared between processes
  bit          hold_request      = 1'b0;
  bit          tx_quiet          = 1'b0;
  bit          rx_quiet          = 1'b0;
  logic [9:0]  low_volt_setting  = LOW_VOLT_RST;
  logic [15:0] max_cur_setting   = MAX_CUR_RST;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bldc_power_limiter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  bpl_result_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  function automatic logic [39:0] pack_beat(input logic [9:0] pv, input logic [16:0] sample,
                                            input logic [9:0] volt, input logic [1:0] mode);
    return {1'b0, mode, volt, sample, pv};
  endfunction

  // Samples across the setpoint range, near zero, large values and noise
  function automatic logic [16:0] draw_sample();
    int unsigned scale;
    scale = int'(max_cur_setting) >> $urandom_range(0, 2);
    case ($urandom_range(0, 4))
      0:       return 17'($urandom);
      1:       return 17'(int'($urandom_range(0, 4000)) - 2000);
      4:       return 17'($urandom_range(20000, 65535));
      default: return 17'($urandom_range(0, scale + 64));
    endcase
  endfunction

  // Mostly near the undervoltage threshold
  function automatic logic [9:0] draw_voltage();
    int v;
    if ($urandom_range(0, 3) == 0) return 10'($urandom);
    v = int'(low_volt_setting) + int'($urandom_range(0, 80)) - 40;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  // Offer one beat after a random gap; return at the falling edge after it is taken
  task automatic send_beat(input logic [1:0] op, input logic [39:0] data);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Optional target change (load or set) followed by a run of ticks in one mode
  task automatic run_sequence(ref int unsigned sent);
    logic [1:0]  mode;
    int unsigned n;
    mode = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: begin send_beat(OPC_LOAD, pack_beat(10'($urandom), 17'($urandom), 10'($urandom), 2'($urandom))); sent++; end
      1: begin send_beat(OPC_SET, pack_beat(10'($urandom), 17'($urandom), 10'($urandom), 2'($urandom))); sent++; end
      default: ;
    endcase
    n = $urandom_range(1, 24);
    repeat (n) begin
      send_beat(OPC_TICK, pack_beat(10'($urandom), draw_sample(), draw_voltage(), mode));
      sent++;
    end
  endtask

  task automatic run_phase(input int unsigned items, input bit with_pressure);
    int unsigned sent;
    logic [1:0]  op;
    bit          pressed;
    sent    = 0;
    pressed = 1'b0;
    while (sent < items) begin
      if (with_pressure && !pressed && sent >= 40) begin
        hold_request = 1'b1;
        pressed      = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        // noise beat, any opcode and any bits
        op = 2'($urandom);
        send_beat(op, {1'b0, 39'($urandom) << 32 ^ 39'($urandom)});
        if (op != OPC_NONE) sent++;
      end else begin
        run_sequence(sent);
      end
    end
    in_tvalid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Both registers in back-to-back writes while idle
  task automatic program_limits(input logic [9:0] lv, input logic [15:0] mc);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_LOW_VOLT;
    cfg_wdata <= {6'd0, lv};
    @(negedge clk);
    cfg_addr  <= REG_MAX_CUR;
    cfg_wdata <= mc;
    @(negedge clk);
    cfg_we    <= 1'b0;
    low_volt_setting = lv;
    max_cur_setting  = mc;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bldc_power_limiter_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset defaults, field extremes, all opcodes, corner cases
    send_beat(OPC_TICK, pack_beat(10'd0,    17'd0,       10'd0,    2'd0));
    send_beat(OPC_LOAD, pack_beat(10'd1023, 17'd0,       10'd0,    2'd0));
    send_beat(OPC_TICK, pack_beat(10'd0,    17'h0FFFF,   10'd1023, 2'd0));
    send_beat(OPC_TICK, pack_beat(10'd0,    17'h10000,   10'd1023, 2'd1));
    send_beat(OPC_TICK, pack_beat(10'd0,    17'd0,       10'd310,  2'd2));
    send_beat(OPC_TICK, pack_beat(10'd0,    17'd5000,    10'd309,  2'd3));
    // unused opcode with every bit set
    send_beat(OPC_NONE, pack_beat(10'h3FF,  17'h1FFFF,   10'h3FF,  2'd3));
    send_beat(OPC_SET,  pack_beat(10'd0,    17'd0,       10'd0,    2'd0));
    send_beat(OPC_TICK, pack_beat(10'd0,    17'd100,     10'd400,  2'd0));
    send_beat(OPC_TICK, pack_beat(10'd0,    17'h18000,   10'd400,  2'd0));
    // small drive pushed negative by undervoltage before the current trim
    send_beat(OPC_LOAD, pack_beat(10'd5,    17'd0,       10'd0,    2'd0));
    send_beat(OPC_TICK, pack_beat(10'd0,    17'd100,     10'd0,    2'd0));
    // sustained undervoltage winds the integral down
    send_beat(OPC_LOAD, pack_beat(10'd700,  17'd0,       10'd0,    2'd0));
    repeat (4) send_beat(OPC_TICK, pack_beat(10'd0, 17'd15000, 10'd200, 2'd0));
    // overcurrent on the raw sample
    send_beat(OPC_SET,  pack_beat(10'd300,  17'd0,       10'd0,    2'd0));
    repeat (3) send_beat(OPC_TICK, pack_beat(10'd0, 17'd40000, 10'd900, 2'd1));
    send_beat(OPC_LOAD, pack_beat(10'd0,    17'd0,       10'd0,    2'd0));
    send_beat(OPC_TICK, pack_beat(10'd1023, 17'h1FFFF,   10'd1023, 2'd2));
    in_tvalid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    // random phases over several limit settings, extremes included
    run_phase(ITEMS_PER_PHASE, 1'b1);
    program_limits(10'd0, 16'd0);
    run_phase(ITEMS_PER_PHASE, 1'b0);
    program_limits(10'd1023, 16'd65535);
    run_phase(ITEMS_PER_PHASE, 1'b0);
    program_limits(10'd0, 16'd65535);
    run_phase(ITEMS_PER_PHASE, 1'b0);
    program_limits(10'd1023, 16'd0);
    run_phase(ITEMS_PER_PHASE, 1'b0);
    program_limits(10'($urandom), 16'($urandom));
    run_phase(ITEMS_PER_PHASE, 1'b0);
    program_limits(LOW_VOLT_RST, MAX_CUR_RST);
    run_phase(ITEMS_PER_PHASE, 1'b0);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("bldc_power_limiter_tb: clean");
    end else begin
      $display("bldc_power_limiter_tb: errors");
    end
    $finish;
  end

endmodule
